// ----- src/dq_pkg.sv -----
package dq_pkg;

    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [2:0] MODE_POP_BACK   = 3'd2;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [2:0] MODE_PEEK_FRONT = 3'd4;
    localparam logic [2:0] MODE_PEEK_BACK  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic             mem_we;
        logic             mem_re;
        logic [PTR_W-1:0] addr;
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [CNT_W-1:0] count;
        logic [1:0]       status;
        logic             full;
        logic             empty;
    } t_op;

endpackage

// ----- src/dq_step.sv -----
module dq_step (
    input  logic [2:0]               i_mode,
    input  logic [dq_pkg::PTR_W-1:0] i_head,
    input  logic [dq_pkg::PTR_W-1:0] i_tail,
    input  logic [dq_pkg::CNT_W-1:0] i_count,
    input  logic [dq_pkg::CNT_W-1:0] i_cap,
    output dq_pkg::t_op              o_op
);
    import dq_pkg::*;

    logic             full;
    logic             empty;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] head_prev;
    logic [PTR_W-1:0] tail_next;
    logic [PTR_W-1:0] tail_prev;
    logic [CNT_W-1:0] head_inc;
    logic [CNT_W-1:0] tail_inc;
    logic [CNT_W-1:0] cap_m1;

    assign full  = (i_count >= i_cap);
    assign empty = (i_count == '0);

    // wrap at the configured capacity, not at the store depth
    assign cap_m1    = i_cap - CNT_W'(1);
    assign head_inc  = CNT_W'(i_head) + CNT_W'(1);
    assign tail_inc  = CNT_W'(i_tail) + CNT_W'(1);
    assign head_next = (head_inc >= i_cap) ? '0 : head_inc[PTR_W-1:0];
    assign tail_next = (tail_inc >= i_cap) ? '0 : tail_inc[PTR_W-1:0];
    assign head_prev = (i_head == '0) ? cap_m1[PTR_W-1:0] : i_head - PTR_W'(1);
    assign tail_prev = (i_tail == '0) ? cap_m1[PTR_W-1:0] : i_tail - PTR_W'(1);

    always_comb begin
        o_op        = '0;
        o_op.head   = i_head;
        o_op.tail   = i_tail;
        o_op.count  = i_count;
        o_op.status = ST_OK;
        unique case (i_mode)
            MODE_PUSH_BACK: begin
                if (full) begin
                    o_op.status = ST_FULL;
                end else begin
                    o_op.mem_we = 1'b1;
                    o_op.addr   = i_tail;
                    o_op.tail   = tail_next;
                    o_op.count  = i_count + CNT_W'(1);
                end
            end
            MODE_PUSH_FRONT: begin
                if (full) begin
                    o_op.status = ST_FULL;
                end else begin
                    o_op.mem_we = 1'b1;
                    o_op.addr   = head_prev;
                    o_op.head   = head_prev;
                    o_op.count  = i_count + CNT_W'(1);
                end
            end
            MODE_POP_BACK: begin
                if (empty) begin
                    o_op.status = ST_EMPTY;
                end else begin
                    o_op.mem_re = 1'b1;
                    o_op.addr   = tail_prev;
                    o_op.tail   = tail_prev;
                    o_op.count  = i_count - CNT_W'(1);
                end
            end
            MODE_POP_FRONT: begin
                if (empty) begin
                    o_op.status = ST_EMPTY;
                end else begin
                    o_op.mem_re = 1'b1;
                    o_op.addr   = i_head;
                    o_op.head   = head_next;
                    o_op.count  = i_count - CNT_W'(1);
                end
            end
            MODE_PEEK_FRONT: begin
                if (empty) begin
                    o_op.status = ST_EMPTY;
                end else begin
                    o_op.mem_re = 1'b1;
                    o_op.addr   = i_head;
                end
            end
            MODE_PEEK_BACK: begin
                if (empty) begin
                    o_op.status = ST_EMPTY;
                end else begin
                    o_op.mem_re = 1'b1;
                    o_op.addr   = tail_prev;
                end
            end
            default: begin
                // unused codes: no operation, flags only
            end
        endcase
        o_op.full  = (o_op.count >= i_cap);
        o_op.empty = (o_op.count == '0);
    end

endmodule

// ----- src/double_ended_ring_queue.sv -----
// A result word passes the stage-one registers, then the output registers.
// Throughput: one word per cycle while o_in_stall is low; the single-port slot
// memory is accessed once per word; pointers and count update on acceptance.
// Reset (synchronous, active low): head, tail and count clear, capacity
// returns to 16, pipeline empties; slot contents are not cleared.
module double_ended_ring_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [4:0]                i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [2:0]                i_mode,
    input  logic signed [31:0]        i_data_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [31:0]        o_data_out,
    output logic [1:0]                o_status,
    output logic [4:0]                o_occupancy,
    output logic                      o_is_full,
    output logic                      o_is_empty
);
    import dq_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] n_cap;

    logic             r_s1_valid;
    logic             r_s1_rd;
    logic [1:0]       r_s1_status;
    logic [CNT_W-1:0] r_s1_count;
    logic             r_s1_full;
    logic             r_s1_empty;
    logic             r_out_valid;

    t_op  op;
    logic in_acc;
    logic out_move;

    dq_step u_step (
        .i_mode  (i_mode),
        .i_head  (r_head),
        .i_tail  (r_tail),
        .i_count (r_count),
        .i_cap   (r_cap),
        .o_op    (op)
    );

    assign out_move   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !out_move;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // clamp capacity into 1..DEPTH
    always_comb begin
        n_cap = i_cfg_data;
        if (i_cfg_data == '0) begin
            n_cap = CNT_W'(1);
        end else if (i_cfg_data > CNT_W'(DEPTH)) begin
            n_cap = CNT_W'(DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_cap       <= CNT_W'(DEPTH);
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap   <= n_cap;
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
            end else if (in_acc) begin
                r_head  <= op.head;
                r_tail  <= op.tail;
                r_count <= op.count;
            end
            r_s1_valid <= in_acc || (r_s1_valid && !out_move);
            if (out_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // slot memory: one access per word, read data registered
    always_ff @(posedge i_clk) begin
        if (in_acc && op.mem_we) begin
            mem[op.addr] <= i_data_in;
        end
        if (in_acc && op.mem_re) begin
            r_rd_data <= mem[op.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_rd     <= op.mem_re;
            r_s1_status <= op.status;
            r_s1_count  <= op.count;
            r_s1_full   <= op.full;
            r_s1_empty  <= op.empty;
        end
        if (out_move && r_s1_valid) begin
            o_data_out  <= r_s1_rd ? r_rd_data : '0;
            o_status    <= r_s1_status;
            o_occupancy <= r_s1_count;
            o_is_full   <= r_s1_full;
            o_is_empty  <= r_s1_empty;
        end
    end

`ifndef ASSERT_OFF
    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("entry count above capacity");

    a_ptr_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'(r_head) < r_cap) && (CNT_W'(r_tail) < r_cap))
        else $error("pointer outside ring");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with split pointers");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_data_out == '0))
        else $error("rejected word carries data");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted word lost");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import dq_pkg::*;

    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int WORDS_PER_PHASE = 130;

    typedef struct {
        logic             is_cfg;
        logic [4:0]       cfg_value;
        logic [2:0]       mode;
        logic [WIDTH-1:0] data;
    } t_stim;

    typedef struct {
        logic [WIDTH-1:0] data;
        logic [1:0]       status;
        logic [CNT_W-1:0] occupancy;
        logic             full;
        logic             empty;
    } t_answer;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [4:0]        i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [2:0]        i_mode      = MODE_PUSH_BACK;
    logic signed [31:0] i_data_in  = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic signed [31:0] o_data_out;
    logic [1:0]        o_status;
    logic [4:0]        o_occupancy;
    logic              o_is_full;
    logic              o_is_empty;

    t_stim   stim_queue[$];
    t_answer deque_answers[$];
    int      error_count  = 0;
    int      cycle_count  = 0;
    int      quiet_cycles = 0;
    int      gap_left     = 0;
    int      stall_left   = 0;
    logic    word_taken   = 1'b0;

    // predictor state
    logic [WIDTH-1:0] slot_copy [DEPTH];
    logic [PTR_W-1:0] head_ptr;
    logic [PTR_W-1:0] tail_ptr;
    logic [CNT_W-1:0] entry_total;
    logic [CNT_W-1:0] ring_size;

    logic [4:0] cap_plan [12] = '{5'd1, 5'd16, 5'd3, 5'd31, 5'd2, 5'd0,
                                  5'd7, 5'd16, 5'd4, 5'd20, 5'd12, 5'd5};

    double_ended_ring_queue u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_data_in   (i_data_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_occupancy (o_occupancy),
        .o_is_full   (o_is_full),
        .o_is_empty  (o_is_empty)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [PTR_W-1:0] ring_step_up(logic [PTR_W-1:0] p);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(p) + CNT_W'(1);
        return (nxt >= ring_size) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_step_down(logic [PTR_W-1:0] p);
        logic [CNT_W-1:0] last;
        last = ring_size - CNT_W'(1);
        return (p == '0) ? last[PTR_W-1:0] : p - PTR_W'(1);
    endfunction

    // capacity write clamps to 1..DEPTH and empties the queue; slots are kept
    function automatic void load_capacity(logic [4:0] v);
        if (v == 5'd0)
            ring_size = CNT_W'(1);
        else if (v > DEPTH)
            ring_size = CNT_W'(DEPTH);
        else
            ring_size = v;
        head_ptr    = '0;
        tail_ptr    = '0;
        entry_total = '0;
    endfunction

    function automatic t_answer apply_deque_op(logic [2:0] mode, logic [WIDTH-1:0] din);
        t_answer a;
        logic    was_full;
        logic    was_empty;
        a.data    = '0;
        a.status  = ST_OK;
        was_full  = (entry_total >= ring_size);
        was_empty = (entry_total == 0);
        case (mode)
            MODE_PUSH_BACK: begin
                if (was_full) begin
                    a.status = ST_FULL;
                end else begin
                    slot_copy[tail_ptr] = din;
                    tail_ptr = ring_step_up(tail_ptr);
                    entry_total = entry_total + CNT_W'(1);
                end
            end
            MODE_PUSH_FRONT: begin
                if (was_full) begin
                    a.status = ST_FULL;
                end else begin
                    head_ptr = ring_step_down(head_ptr);
                    slot_copy[head_ptr] = din;
                    entry_total = entry_total + CNT_W'(1);
                end
            end
            MODE_POP_BACK: begin
                if (was_empty) begin
                    a.status = ST_EMPTY;
                end else begin
                    tail_ptr = ring_step_down(tail_ptr);
                    a.data = slot_copy[tail_ptr];
                    entry_total = entry_total - CNT_W'(1);
                end
            end
            MODE_POP_FRONT: begin
                if (was_empty) begin
                    a.status = ST_EMPTY;
                end else begin
                    a.data = slot_copy[head_ptr];
                    head_ptr = ring_step_up(head_ptr);
                    entry_total = entry_total - CNT_W'(1);
                end
            end
            MODE_PEEK_FRONT: begin
                if (was_empty)
                    a.status = ST_EMPTY;
                else
                    a.data = slot_copy[head_ptr];
            end
            MODE_PEEK_BACK: begin
                if (was_empty)
                    a.status = ST_EMPTY;
                else
                    a.data = slot_copy[ring_step_down(tail_ptr)];
            end
            default: ;
        endcase
        a.occupancy = entry_total;
        a.full      = (entry_total >= ring_size);
        a.empty     = (entry_total == 0);
        return a;
    endfunction

    function automatic int idle_length();
        int r;
        if (quiet_cycles > 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 50);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic add_word(logic [2:0] mode, logic [WIDTH-1:0] data);
        t_stim s;
        s.is_cfg    = 1'b0;
        s.cfg_value = '0;
        s.mode      = mode;
        s.data      = data;
        stim_queue  = {stim_queue, s};
    endtask

    task automatic add_cfg(logic [4:0] v);
        t_stim s;
        s.is_cfg    = 1'b1;
        s.cfg_value = v;
        s.mode      = MODE_PUSH_BACK;
        s.data      = '0;
        stim_queue  = {stim_queue, s};
    endtask

    // runs of words lean toward pushes or pops so that both full and empty are reached
    task automatic add_random_words(int count);
        int          run_left;
        int          push_bias;
        int          r;
        logic [2:0]  mode;
        logic [31:0] data;
        run_left  = 0;
        push_bias = 50;
        repeat (count) begin
            if (run_left == 0) begin
                run_left = $urandom_range(10, 48);
                case ($urandom_range(0, 2))
                    0: push_bias = 85;
                    1: push_bias = 50;
                    default: push_bias = 15;
                endcase
            end
            run_left--;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
            end else if ($urandom_range(0, 99) < push_bias) begin
                mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            end else begin
                case ($urandom_range(0, 5))
                    0, 1: mode = MODE_POP_BACK;
                    2, 3: mode = MODE_POP_FRONT;
                    4: mode = MODE_PEEK_FRONT;
                    default: mode = MODE_PEEK_BACK;
                endcase
            end
            case ($urandom_range(0, 19))
                0: data = 32'h7fffffff;
                1: data = 32'h80000000;
                2: data = 32'h00000000;
                3: data = 32'hffffffff;
                default: data = $urandom;
            endcase
            add_word(mode, data);
        end
    endtask

    initial begin
        // empty queue at reset capacity
        add_word(MODE_POP_FRONT, 32'h0);
        add_word(MODE_POP_BACK, 32'h0);
        add_word(MODE_PEEK_FRONT, 32'h0);
        add_word(MODE_PEEK_BACK, 32'h0);
        add_word(MODE_PUSH_BACK, 32'h7fffffff);
        add_word(MODE_PUSH_FRONT, 32'h80000000);
        add_word(MODE_PUSH_BACK, 32'hffffffff);
        add_word(MODE_PEEK_FRONT, 32'h0);
        add_word(MODE_PEEK_BACK, 32'h0);
        add_word(MODE_SPARE_LO, 32'h12345678);
        add_word(MODE_SPARE_HI, 32'h0);
        add_word(MODE_POP_BACK, 32'h0);
        add_word(MODE_POP_FRONT, 32'h0);
        add_word(MODE_POP_FRONT, 32'h0);
        add_word(MODE_POP_BACK, 32'h0);
        // tiny ring: wrap at the front, then full
        add_cfg(5'd2);
        add_word(MODE_PUSH_FRONT, 32'h5a5a5a5a);
        add_word(MODE_PUSH_FRONT, 32'h00000000);
        add_word(MODE_PUSH_BACK, 32'h00000001);
        add_word(MODE_PUSH_FRONT, 32'h00000002);
        add_word(MODE_POP_BACK, 32'h0);
        add_word(MODE_POP_BACK, 32'h0);
        // zero capacity acts as one
        add_cfg(5'd0);
        add_word(MODE_PUSH_BACK, 32'hdeadbeef);
        add_word(MODE_PUSH_BACK, 32'h0badf00d);
        add_word(MODE_PEEK_BACK, 32'h0);
        add_word(MODE_POP_FRONT, 32'h0);

        for (int p = 0; p < 12; p++) begin
            add_cfg(cap_plan[p]);
            add_random_words(WORDS_PER_PHASE);
        end
        repeat (2) begin
            add_cfg(5'($urandom_range(0, 31)));
            add_random_words(WORDS_PER_PHASE);
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
            #1;
        end while (stim_queue.size() != 0 || i_in_valid || i_cfg_we
                   || deque_answers.size() != 0);
        repeat (8) @(posedge i_clk);
        if (deque_answers.size() != 0)
            report_mismatch("missing results", deque_answers.size(), 0);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin : check_proc
        t_answer want;
        cycle_count <= cycle_count + 1;
        if (quiet_cycles > 0)
            quiet_cycles <= quiet_cycles - 1;
        else if ($urandom_range(0, 399) == 0)
            quiet_cycles <= $urandom_range(30, 120);
        if (!i_rst_n) begin
            ring_size   = CNT_W'(DEPTH);
            head_ptr    = '0;
            tail_ptr    = '0;
            entry_total = '0;
            word_taken  <= 1'b0;
        end else begin
            // check first so a word accepted on this edge cannot match its own result
            if (o_out_valid && !i_out_stall) begin
                if (deque_answers.size() == 0) begin
                    report_mismatch("result with no word pending", o_data_out, 0);
                end else begin
                    want = deque_answers[0];
                    deque_answers.delete(0);
                    if (o_data_out !== want.data)
                        report_mismatch("data_out", o_data_out, want.data);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                    if (o_occupancy !== want.occupancy)
                        report_mismatch("occupancy", o_occupancy, want.occupancy);
                    if (o_is_full !== want.full)
                        report_mismatch("is_full", o_is_full, want.full);
                    if (o_is_empty !== want.empty)
                        report_mismatch("is_empty", o_is_empty, want.empty);
                end
            end
            if (i_cfg_we)
                load_capacity(i_cfg_data);
            if (i_in_valid && !o_in_stall)
                deque_answers = {deque_answers, apply_deque_op(i_mode, i_data_in)};
            word_taken <= i_in_valid && !o_in_stall;
        end
    end

    always @(negedge i_clk) begin : drive_proc
        t_stim              item;
        logic               nxt_valid;
        logic               nxt_we;
        logic [4:0]         nxt_cfg;
        logic [2:0]         nxt_mode;
        logic signed [31:0] nxt_data;
        nxt_valid = i_in_valid;
        nxt_we    = 1'b0;
        nxt_cfg   = i_cfg_data;
        nxt_mode  = i_mode;
        nxt_data  = i_data_in;
        if (i_rst_n && !(i_in_valid && !word_taken)) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
            end else if (stim_queue.size() != 0) begin
                if (stim_queue[0].is_cfg) begin
                    // write the capacity only once every result is back
                    if (deque_answers.size() == 0) begin
                        item    = stim_queue[0];
                        stim_queue.delete(0);
                        nxt_we  = 1'b1;
                        nxt_cfg = item.cfg_value;
                    end
                end else begin
                    item      = stim_queue[0];
                    stim_queue.delete(0);
                    nxt_valid = 1'b1;
                    nxt_mode  = item.mode;
                    nxt_data  = item.data;
                    gap_left  = idle_length();
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_cfg_we   <= nxt_we;
        i_cfg_data <= nxt_cfg;
        i_mode     <= nxt_mode;
        i_data_in  <= nxt_data;
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = idle_length();
        end
    end

endmodule

// ----- sim.f -----
src/dq_pkg.sv
src/dq_step.sv
src/double_ended_ring_queue.sv
test/testbench.sv
